// File: design/rtf_text_escape_encoder_macros.svh
`ifndef RTF_TEXT_ESCAPE_ENCODER_MACROS_SVH
`define RTF_TEXT_ESCAPE_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define RTFESC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtfesc check failed");
`define RTFESC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtfesc check failed");
`else
`define RTFESC_ASSERT_SAME(label, clk, rst, ante, cons)
`define RTFESC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: design/rtfesc_pkg.sv
`default_nettype none
package rtfesc_pkg;

   localparam int MaxBytes   = 11;
   localparam int CountWidth = 4;
   localparam int NumDigits  = 5;
   localparam int DivShift   = 19;
   localparam logic [15:0] DivMul = 16'd52429;

   localparam logic [15:0] CODE_TAB         = 16'h0009;
   localparam logic [15:0] CODE_BACKSLASH   = 16'h005C;
   localparam logic [15:0] CODE_LBRACE      = 16'h007B;
   localparam logic [15:0] CODE_RBRACE      = 16'h007D;
   localparam logic [15:0] CODE_ASCII_MAX   = 16'd127;
   localparam logic [15:0] CODE_NBSP        = 16'h00A0;
   localparam logic [15:0] CODE_SHY         = 16'h00AD;
   localparam logic [15:0] CODE_ENDASH      = 16'h2013;
   localparam logic [15:0] CODE_EMDASH      = 16'h2014;
   localparam logic [15:0] CODE_LQUOTE      = 16'h2018;
   localparam logic [15:0] CODE_RQUOTE      = 16'h2019;
   localparam logic [15:0] CODE_LDBLQUOTE   = 16'h201C;
   localparam logic [15:0] CODE_RDBLQUOTE   = 16'h201D;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_TILDE     = 8'h7E;
   localparam logic [7:0] CHAR_HYPHEN    = 8'h2D;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;

   typedef enum logic [1:0] {
      KIND_LIT,
      KIND_ESC,
      KIND_WORD,
      KIND_UNI
   } kind_type;

   typedef enum logic [2:0] {
      WORD_TAB,
      WORD_EMDASH,
      WORD_ENDASH,
      WORD_LQUOTE,
      WORD_RQUOTE,
      WORD_LDBLQUOTE,
      WORD_RDBLQUOTE
   } word_type;

   typedef logic [MaxBytes-1:0][7:0] byte_vec_type;

   typedef struct packed {
      kind_type                   kind;
      word_type                   word;
      logic                       neg;
      logic [7:0]                 lit;
      logic [15:0]                rem;
      logic [NumDigits-1:0][3:0]  digits;
   } item_type;

   function automatic logic [8*MaxBytes-1:0] word_text(input word_type w);
      logic [8*MaxBytes-1:0] t;
      unique case (w)
         WORD_TAB:       t = {"\\tab ", 48'h0};
         WORD_EMDASH:    t = {"\\emdash ", 24'h0};
         WORD_ENDASH:    t = {"\\endash ", 24'h0};
         WORD_LQUOTE:    t = {"\\lquote ", 24'h0};
         WORD_RQUOTE:    t = {"\\rquote ", 24'h0};
         WORD_LDBLQUOTE: t = "\\ldblquote ";
         WORD_RDBLQUOTE: t = "\\rdblquote ";
         default:        t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [CountWidth-1:0] word_len(input word_type w);
      logic [CountWidth-1:0] n;
      unique case (w)
         WORD_TAB:       n = 4'd5;
         WORD_EMDASH:    n = 4'd8;
         WORD_ENDASH:    n = 4'd8;
         WORD_LQUOTE:    n = 4'd8;
         WORD_RQUOTE:    n = 4'd8;
         WORD_LDBLQUOTE: n = 4'd11;
         WORD_RDBLQUOTE: n = 4'd11;
         default:        n = 4'd1;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

// File: design/rtfesc_classify.sv
`default_nettype none
module rtfesc_classify
   import rtfesc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic        in_valid,
   input  wire logic [15:0] code,
   output item_type         item_out,
   output logic             valid_out
);

   item_type item_ff, item_in;
   logic     valid_ff;

   always_comb begin
      item_in        = '0;
      item_in.kind   = KIND_LIT;
      item_in.word   = WORD_TAB;
      item_in.lit    = code[7:0];
      item_in.neg    = code[15];
      item_in.rem    = code[15] ? 16'(~code + 16'd1) : code;
      item_in.digits = '0;
      priority if (code == CODE_BACKSLASH || code == CODE_LBRACE || code == CODE_RBRACE) begin
         item_in.kind = KIND_ESC;
      end else if (code == CODE_TAB) begin
         item_in.kind = KIND_WORD;
         item_in.word = WORD_TAB;
      end else if (code == CODE_NBSP) begin
         item_in.kind = KIND_ESC;
         item_in.lit  = CHAR_TILDE;
      end else if (code == CODE_SHY) begin
         item_in.kind = KIND_ESC;
         item_in.lit  = CHAR_HYPHEN;
      end else if (code == CODE_EMDASH) begin
         item_in.kind = KIND_WORD;
         item_in.word = WORD_EMDASH;
      end else if (code == CODE_ENDASH) begin
         item_in.kind = KIND_WORD;
         item_in.word = WORD_ENDASH;
      end else if (code == CODE_LQUOTE) begin
         item_in.kind = KIND_WORD;
         item_in.word = WORD_LQUOTE;
      end else if (code == CODE_RQUOTE) begin
         item_in.kind = KIND_WORD;
         item_in.word = WORD_RQUOTE;
      end else if (code == CODE_LDBLQUOTE) begin
         item_in.kind = KIND_WORD;
         item_in.word = WORD_LDBLQUOTE;
      end else if (code == CODE_RDBLQUOTE) begin
         item_in.kind = KIND_WORD;
         item_in.word = WORD_RDBLQUOTE;
      end else if (code > CODE_ASCII_MAX) begin
         item_in.kind = KIND_UNI;
      end else begin
         item_in.kind = KIND_LIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign item_out  = item_ff;
   assign valid_out = valid_ff;

endmodule
`default_nettype wire

// File: design/rtfesc_digit.sv
`default_nettype none
module rtfesc_digit
   import rtfesc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,
   input  wire logic in_valid,
   input  item_type  item_in_d,
   output item_type  item_out,
   output logic      valid_out
);

   item_type    item_ff, item_in;
   logic        valid_ff;
   logic [31:0] prod;
   logic [15:0] quot;
   logic [15:0] tenfold;
   logic [3:0]  digit;

   always_comb begin
      prod    = item_in_d.rem * DivMul;
      quot    = 16'(prod >> DivShift);
      tenfold = 16'((quot << 3) + (quot << 1));
      digit   = 4'(item_in_d.rem - tenfold);
      item_in = item_in_d;
      item_in.rem    = quot;
      item_in.digits = {digit, item_in_d.digits[NumDigits-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign item_out  = item_ff;
   assign valid_out = valid_ff;

endmodule
`default_nettype wire

// File: design/rtfesc_serial.sv
`default_nettype none
module rtfesc_serial
   import rtfesc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  load,
   input  item_type   item,
   output logic       load_ok,
   output logic       strobe,
   output logic [7:0] out_byte,
   output logic       run_end
);

   byte_vec_type          buf_ff, buf_in, arr;
   logic [CountWidth-1:0] count_ff, count_in, len;
   logic [2:0]            ndig;
   logic [CountWidth-1:0] base;
   logic [2:0]            sel;
   logic [8*MaxBytes-1:0] text;

   always_comb begin
      arr  = '0;
      len  = 4'd1;
      text = word_text(item.word);
      sel  = '0;
      priority if (item.digits[4] != 4'd0) begin
         ndig = 3'd5;
      end else if (item.digits[3] != 4'd0) begin
         ndig = 3'd4;
      end else if (item.digits[2] != 4'd0) begin
         ndig = 3'd3;
      end else if (item.digits[1] != 4'd0) begin
         ndig = 3'd2;
      end else begin
         ndig = 3'd1;
      end
      base = 4'd2 + {3'd0, item.neg};
      unique case (item.kind)
         KIND_LIT: begin
            arr[0] = item.lit;
            len    = 4'd1;
         end
         KIND_ESC: begin
            arr[0] = CHAR_BACKSLASH;
            arr[1] = item.lit;
            len    = 4'd2;
         end
         KIND_WORD: begin
            for (int i = 0; i < MaxBytes; i++) begin
               arr[i] = text[8*(MaxBytes-i)-1 -: 8];
            end
            len = word_len(item.word);
         end
         KIND_UNI: begin
            arr[0] = CHAR_BACKSLASH;
            arr[1] = CHAR_U;
            if (item.neg) begin
               arr[2] = CHAR_HYPHEN;
            end
            for (int j = 0; j < NumDigits; j++) begin
               if (3'(j) < ndig) begin
                  sel = 3'(ndig - 3'(j) - 3'd1);
                  arr[base + 4'(j)] = CHAR_ZERO + {4'd0, item.digits[sel]};
               end
            end
            arr[base + {1'b0, ndig}] = CHAR_QUESTION;
            len = base + {1'b0, ndig} + 4'd1;
         end
         default: begin
            arr[0] = item.lit;
            len    = 4'd1;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         buf_in   = arr;
         count_in = len;
      end else begin
         buf_in   = {8'd0, buf_ff[MaxBytes-1:1]};
         count_in = (count_ff != '0) ? count_ff - 4'd1 : count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign load_ok  = (count_ff <= 4'd1);
   assign strobe   = (count_ff != '0);
   assign out_byte = buf_ff[0];
   assign run_end  = (count_ff == 4'd1);

endmodule
`default_nettype wire

// File: design/rtf_text_escape_encoder.sv
// Channel   Ports                                  Handshake
// request   start, busy, req_code_unit             taken when start && !busy
// response  rsp_strobe, rsp_out_byte, rsp_run_end  one byte per strobe cycle, no stall
//
// A request reaches the first byte of its run through a classify stage, five
// digit stages (one decimal digit each via reciprocal multiply) and the byte shifter.
// The shifter sends one byte a cycle; a request's run has 1 to 11 bytes, and
// runs of one byte sustain one request a cycle.
// busy rises while the last pipeline stage holds a request and the shifter
// still has two or more bytes to send; the whole pipeline then holds.
// Synchronous reset clears the valid bits and the shifter count.
`default_nettype none
`include "rtf_text_escape_encoder_macros.svh"
module rtf_text_escape_encoder
   import rtfesc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_code_unit,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_end
);

   item_type stage_item  [NumDigits+1];
   logic     stage_valid [NumDigits+1];
   logic     advance;
   logic     load_ok;

   assign advance = load_ok || !stage_valid[NumDigits];
   assign busy    = !advance;

   rtfesc_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (start),
      .code      (req_code_unit),
      .item_out  (stage_item[0]),
      .valid_out (stage_valid[0])
   );

   for (genvar g = 0; g < NumDigits; g++) begin : g_digit
      rtfesc_digit u_digit (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[g]),
         .item_in_d (stage_item[g]),
         .item_out  (stage_item[g+1]),
         .valid_out (stage_valid[g+1])
      );
   end

   rtfesc_serial u_serial (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && stage_valid[NumDigits]),
      .item     (stage_item[NumDigits]),
      .load_ok  (load_ok),
      .strobe   (rsp_strobe),
      .out_byte (rsp_out_byte),
      .run_end  (rsp_run_end)
   );

   `RTFESC_ASSERT_SAME(a_busy_mid_run, clock, reset, busy, rsp_strobe && !rsp_run_end)
   `RTFESC_ASSERT_NEXT(a_busy_keeps_run, clock, reset, busy, rsp_strobe)
   `RTFESC_ASSERT_NEXT(a_run_unbroken, clock, reset, rsp_strobe && !rsp_run_end, rsp_strobe)

endmodule
`default_nettype wire

// File: tb/rtf_text_escape_encoder_checker.sv
`timescale 1ns / 100ps
module rtf_text_escape_encoder_checker
   import rtfesc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [15:0] req_code_unit,
   input  logic        rsp_strobe,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_run_end,
   output int          failures,
   output int          outstanding
);

   typedef struct packed {
      logic [7:0] text_byte;
      logic       run_last;
   } escaped_byte_type;

   escaped_byte_type escaped_bytes[$];
   logic [7:0]       run_text[$];

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      failures = failures + 1;
   endtask

   function automatic void push_word(input string s);
      for (int i = 0; i < s.len(); i++) begin
         run_text.push_back(s[i]);
      end
   endfunction

   task automatic predict_escape(input logic [15:0] code);
      logic [15:0]      mag;
      logic [7:0]       digits[5];
      int               n;
      escaped_byte_type item;
      run_text.delete();
      n = 0;
      case (code)
         CODE_BACKSLASH: push_word("\\\\");
         CODE_LBRACE:    push_word("\\{");
         CODE_RBRACE:    push_word("\\}");
         CODE_TAB:       push_word("\\tab ");
         CODE_NBSP:      push_word("\\~");
         CODE_SHY:       push_word("\\-");
         CODE_EMDASH:    push_word("\\emdash ");
         CODE_ENDASH:    push_word("\\endash ");
         CODE_LQUOTE:    push_word("\\lquote ");
         CODE_RQUOTE:    push_word("\\rquote ");
         CODE_LDBLQUOTE: push_word("\\ldblquote ");
         CODE_RDBLQUOTE: push_word("\\rdblquote ");
         default: begin
            if (code > CODE_ASCII_MAX) begin
               run_text.push_back(CHAR_BACKSLASH);
               run_text.push_back(CHAR_U);
               if (code[15]) begin
                  run_text.push_back(CHAR_HYPHEN);
                  mag = 16'h0000 - code;
               end else begin
                  mag = code;
               end
               do begin
                  digits[n] = CHAR_ZERO + 8'(mag % 16'd10);
                  n = n + 1;
                  mag = mag / 16'd10;
               end while (mag != 16'd0 && n < 5);
               while (n > 0) begin
                  n = n - 1;
                  run_text.push_back(digits[n]);
               end
               run_text.push_back(CHAR_QUESTION);
            end else begin
               run_text.push_back(code[7:0]);
            end
         end
      endcase
      for (int i = 0; i < run_text.size(); i++) begin
         item.text_byte = run_text[i];
         item.run_last  = (i == run_text.size() - 1);
         escaped_bytes.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      escaped_byte_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (escaped_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h run_end %0b",
                                         rsp_out_byte, rsp_run_end));
            end else begin
               want = escaped_bytes.pop_front();
               if (rsp_out_byte !== want.text_byte)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_out_byte, want.text_byte));
               if (rsp_run_end !== want.run_last)
                  report_mismatch($sformatf("run_end %0b, want %0b on byte %02h",
                                            rsp_run_end, want.run_last, want.text_byte));
            end
         end
         if (start && !busy) begin
            predict_escape(req_code_unit);
         end
      end
      outstanding = escaped_bytes.size();
   end

endmodule

// File: tb/rtf_text_escape_encoder_tb.sv
`timescale 1ns / 100ps
module rtf_text_escape_encoder_tb
   import rtfesc_pkg::*;
();

   localparam int IdleLimit   = 2000;
   localparam int RandomCount = 330;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [15:0] req_code_unit = 16'h0000;
   logic        busy;
   logic        rsp_strobe;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_end;
   int          failures;
   int          outstanding;

   logic [15:0] special_codes[12] = '{
      CODE_BACKSLASH, CODE_LBRACE, CODE_RBRACE, CODE_TAB, CODE_NBSP, CODE_SHY,
      CODE_EMDASH, CODE_ENDASH, CODE_LQUOTE, CODE_RQUOTE, CODE_LDBLQUOTE,
      CODE_RDBLQUOTE
   };

   logic [15:0] directed_codes[24] = '{
      16'h0000, 16'h007F, 16'h0080, 16'hFFFF, 16'h8000, 16'h7FFF,
      CODE_BACKSLASH, CODE_LBRACE, CODE_RBRACE, CODE_TAB, CODE_NBSP, CODE_SHY,
      CODE_ENDASH, CODE_EMDASH, CODE_LQUOTE, CODE_RQUOTE, CODE_LDBLQUOTE,
      CODE_RDBLQUOTE, 16'hD800, 16'hDFFF, 16'h0041, 16'h00FF, 16'h2710, 16'h03E7
   };

   rtf_text_escape_encoder dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_code_unit (req_code_unit),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_end   (rsp_run_end)
   );

   rtf_text_escape_encoder_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_code_unit (req_code_unit),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_end   (rsp_run_end),
      .failures      (failures),
      .outstanding   (outstanding)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe)
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_request(input logic [15:0] code, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_code_unit <= code;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic int draw_gap(input int index);
      if ((index / 40) % 3 == 1) return 0;
      return $urandom_range(0, 15);
   endfunction

   function automatic logic [15:0] draw_code();
      int kind;
      int k;
      int lo;
      int hi;
      int mag;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: return 16'($urandom_range(0, 127));
         3, 4:    return special_codes[$urandom_range(0, 11)];
         7: begin
            k  = $urandom_range(3, 5);
            lo = (k == 3) ? 128 : 10 ** (k - 1);
            hi = (k == 5) ? 32767 : 10 ** k - 1;
            return 16'($urandom_range(hi, lo));
         end
         8: begin
            k   = $urandom_range(1, 5);
            lo  = 10 ** (k - 1);
            hi  = (k == 5) ? 32768 : 10 ** k - 1;
            mag = $urandom_range(hi, lo);
            return 16'(65536 - mag);
         end
         9:       return 16'($urandom_range(16'hDFFF, 16'hD800));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_codes[i]) begin
         send_request(directed_codes[i], (i < 8) ? 0 : $urandom_range(0, 15));
      end
      for (int i = 0; i < RandomCount; i++) begin
         send_request(draw_code(), draw_gap(i));
      end
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/rtfesc_pkg.sv
design/rtfesc_classify.sv
design/rtfesc_digit.sv
design/rtfesc_serial.sv
design/rtf_text_escape_encoder.sv
tb/rtf_text_escape_encoder_checker.sv
tb/rtf_text_escape_encoder_tb.sv
